// ===== sv/bmb_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bmb_pkg
// Shared constants for the box mean blur with clamped edges.
// ---------------------------------------------------------------------------
package bmb_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxRadiusXDef = 7;
  localparam int unsigned MaxRadiusYDef = 7;

  localparam int unsigned HeightMax = 4096;
  localparam int unsigned RowW      = 12;
  localparam int unsigned HeightW   = 13;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgWidthW = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned CfgRadW   = 3;

  localparam logic [CfgIdxW-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHalfWidth   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHalfHeight  = 2'd3;

  localparam logic [CfgWidthW-1:0]  ImageWidthRst  = 11'd1024;
  localparam logic [CfgHeightW-1:0] ImageHeightRst = 13'd1;
  localparam logic [CfgRadW-1:0]    HalfWidthRst   = 3'd1;
  localparam logic [CfgRadW-1:0]    HalfHeightRst  = 3'd1;

  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

endpackage
`default_nettype wire

// ===== sv/bmb_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bmb_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bmb_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule
`default_nettype wire

// ===== sv/box_mean_blur_clamped_edges.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// box_mean_blur_clamped_edges
// Streaming box mean filter with edge clamping for 8-bit grey images.
// ---------------------------------------------------------------------------
// Channel   Dir  Fields
// s_axis    in   tdata: pixel_in[7:0]; tuser: cmd (1 = drain)
// m_axis    out  tdata: blurred_pixel[7:0]; tlast: frame_last
// cfg       in   cfg_idx_i selects image_width, image_height, half_width, half_height
//
// A beat that gives no result leaves the block ready for the next beat. A beat
// that gives a result holds off the next beat while the block reads each window
// pixel from memory in turn, closes the sum, and forms the mean in a
// one-bit-per-cycle divider.
// No clearing pass follows reset. A result waits in the output register while
// the next beat is taken; a stalled output holds the block only when a new
// result is ready.
// ---------------------------------------------------------------------------
module box_mean_blur_clamped_edges #(
  parameter int unsigned MAX_WIDTH    = bmb_pkg::MaxWidthDef,
  parameter int unsigned MAX_RADIUS_X = bmb_pkg::MaxRadiusXDef,
  parameter int unsigned MAX_RADIUS_Y = bmb_pkg::MaxRadiusYDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire logic [7:0]               s_axis_tdata,   // pixel_in[7:0]
  input  wire logic                     s_axis_tuser,   // cmd
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // blurred_pixel[7:0]
  output logic                          m_axis_tlast,
  input  wire logic                     cfg_we_i,
  input  wire logic [bmb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bmb_pkg::CfgDataW-1:0] cfg_data_i
);
  import bmb_pkg::*;

  localparam int unsigned RING     = 2 * MAX_RADIUS_Y + MAX_RADIUS_X + 2;
  localparam int unsigned RG_W     = $clog2(RING);
  localparam int unsigned MEM_D    = RING * MAX_WIDTH;
  localparam int unsigned AW       = $clog2(MEM_D);
  localparam int unsigned CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RXW      = $clog2(MAX_RADIUS_X + 2);
  localparam int unsigned RYW      = $clog2(MAX_RADIUS_Y + 2);
  localparam int unsigned IW       = $clog2(2 * MAX_RADIUS_X + 2);
  localparam int unsigned JW       = $clog2(2 * MAX_RADIUS_Y + 2);
  localparam int unsigned AREA_MAX = (2 * MAX_RADIUS_X + 1) * (2 * MAX_RADIUS_Y + 1);
  localparam int unsigned AREA_W   = $clog2(AREA_MAX + 1);
  localparam int unsigned SUM_W    = $clog2(AREA_MAX * 256 + 1);
  localparam int unsigned LAG_W    = $clog2(MAX_RADIUS_Y * MAX_WIDTH + MAX_RADIUS_X + 2);
  localparam int unsigned CX_W     = CW + 2;
  localparam int unsigned RY_W     = RowW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TAIL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [CfgWidthW-1:0]  image_width_q;
  logic [CfgHeightW-1:0] image_height_q;
  logic [CfgRadW-1:0]    half_width_q;
  logic [CfgRadW-1:0]    half_height_q;

  logic [CW-1:0]    in_col_q, out_col_q;
  logic [RowW-1:0]  in_row_q, out_row_q;
  logic [RG_W-1:0]  in_ring_q, out_ring_q, win_ring_q;
  logic             in_done_q;
  logic [LAG_W-1:0] diff_q;

  logic [IW-1:0]           i_q;
  logic [JW-1:0]           j_q;
  logic signed [CX_W-1:0]  cx_q;
  logic signed [RY_W-1:0]  ry_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    rd_v_q;
  logic [7:0]              mem_rd_q;
  logic [7:0]              res_q;
  logic                    res_last_q;

  logic [7:0] mem_q [MEM_D];

  logic [WW-1:0]      eff_w;
  logic [HeightW-1:0] eff_h;
  logic [RXW-1:0]     eff_dx;
  logic [RYW-1:0]     eff_dy;
  logic [LAG_W-1:0]   lag;
  logic [AREA_W-1:0]  area;

  always_comb begin
    if (image_width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_q);
    end
    if (image_height_q == '0) begin
      eff_h = HeightW'(1);
    end else if (32'(image_height_q) > 32'(HeightMax)) begin
      eff_h = HeightW'(HeightMax);
    end else begin
      eff_h = image_height_q;
    end
    eff_dx = (32'(half_width_q) > 32'(MAX_RADIUS_X)) ? RXW'(MAX_RADIUS_X)
                                                      : RXW'(half_width_q);
    eff_dy = (32'(half_height_q) > 32'(MAX_RADIUS_Y)) ? RYW'(MAX_RADIUS_Y)
                                                       : RYW'(half_height_q);
  end

  assign lag  = LAG_W'(32'(eff_dy) * 32'(eff_w) + 32'(eff_dx));
  assign area = AREA_W'((32'(eff_dx) * 2 + 1) * (32'(eff_dy) * 2 + 1));

  logic               accept;
  logic               store;
  logic               start_emit;
  logic [LAG_W-1:0]   diff_inc;
  logic [AW-1:0]      waddr, raddr;
  logic               mem_re;
  logic [CW-1:0]      xx;
  logic signed [CX_W-1:0] w_last_s;
  logic signed [RY_W-1:0] h_last_s;
  logic signed [RY_W-1:0] ry_init, ry_next;
  logic [RG_W-1:0]    ring_init;
  logic signed [CX_W-1:0] cx_init;
  logic [IW-1:0]      i_last;
  logic [JW-1:0]      j_last;
  logic               out_free;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_num;
  logic [SUM_W-1:0]   div_quo;
  logic               load_out;
  logic               win_last;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign store    = accept && !in_done_q && (s_axis_tuser == CmdPixel);
  assign diff_inc = diff_q + LAG_W'(1);
  assign start_emit = accept && (in_done_q || (store && (diff_inc > lag)));

  assign waddr = AW'(32'(in_ring_q) * MAX_WIDTH) + AW'(in_col_q);

  assign w_last_s = $signed(CX_W'(eff_w - WW'(1)));
  assign h_last_s = $signed(RY_W'(eff_h - HeightW'(1)));

  always_comb begin
    if (cx_q < 0) begin
      xx = '0;
    end else if (cx_q > w_last_s) begin
      xx = CW'(w_last_s);
    end else begin
      xx = CW'(cx_q);
    end
  end

  assign raddr  = AW'(32'(win_ring_q) * MAX_WIDTH) + AW'(xx);
  assign mem_re = (state_q == ST_SUM);

  assign cx_init = $signed(CX_W'(out_col_q)) - $signed(CX_W'(eff_dx));
  assign ry_init = $signed(RY_W'(out_row_q)) - $signed(RY_W'(eff_dy));
  assign ry_next = ry_q + RY_W'(1);
  assign i_last  = IW'({eff_dx, 1'b0});
  assign j_last  = JW'({eff_dy, 1'b0});

  always_comb begin
    if (ry_init < 0) begin
      ring_init = '0;
    end else if (32'(out_ring_q) >= 32'(eff_dy)) begin
      ring_init = RG_W'(32'(out_ring_q) - 32'(eff_dy));
    end else begin
      ring_init = RG_W'(32'(out_ring_q) + RING - 32'(eff_dy));
    end
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign div_start = (state_q == ST_TAIL);
  assign div_num   = sum_q + (rd_v_q ? SUM_W'(mem_rd_q) : SUM_W'(0))
                   + SUM_W'(area >> 1);
  assign load_out  = ((state_q == ST_DIV && div_done) || state_q == ST_OUT) && out_free;
  assign win_last  = (32'(out_row_q) == 32'(eff_h) - 1) && (32'(out_col_q) == 32'(eff_w) - 1);

  bmb_div #(
    .NUM_W(SUM_W),
    .DEN_W(AREA_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (area),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[waddr] <= s_axis_tdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      res_q      <= div_quo[7:0];
      res_last_q <= win_last;
    end
    if (load_out) begin
      m_axis_tdata <= (state_q == ST_DIV) ? div_quo[7:0] : res_q;
      m_axis_tlast <= (state_q == ST_DIV) ? win_last : res_last_q;
    end
    if (state_q == ST_IDLE) begin
      sum_q <= '0;
    end else if (rd_v_q) begin
      sum_q <= sum_q + SUM_W'(mem_rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
      half_width_q   <= HalfWidthRst;
      half_height_q  <= HalfHeightRst;
      in_col_q       <= '0;
      in_row_q       <= '0;
      in_ring_q      <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_ring_q     <= '0;
      in_done_q      <= 1'b0;
      diff_q         <= '0;
      i_q            <= '0;
      j_q            <= '0;
      cx_q           <= '0;
      ry_q           <= '0;
      win_ring_q     <= '0;
      rd_v_q         <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      rd_v_q <= mem_re;
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegImageWidth:  image_width_q  <= CfgWidthW'(cfg_data_i);
          RegImageHeight: image_height_q <= cfg_data_i;
          RegHalfWidth:   half_width_q   <= CfgRadW'(cfg_data_i);
          RegHalfHeight:  half_height_q  <= CfgRadW'(cfg_data_i);
          default: ;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_ring_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_ring_q <= '0;
        in_done_q  <= 1'b0;
        diff_q     <= '0;
      end

      case (state_q)
        ST_IDLE: begin
          if (store) begin
            diff_q <= diff_inc;
            if (32'(in_col_q) + 1 >= 32'(eff_w)) begin
              in_col_q <= '0;
              if (32'(in_row_q) + 1 >= 32'(eff_h)) begin
                in_row_q  <= '0;
                in_ring_q <= '0;
                in_done_q <= 1'b1;
              end else begin
                in_row_q  <= in_row_q + RowW'(1);
                in_ring_q <= (32'(in_ring_q) == RING - 1) ? '0 : in_ring_q + RG_W'(1);
              end
            end else begin
              in_col_q <= in_col_q + CW'(1);
            end
          end
          if (start_emit) begin
            i_q        <= '0;
            j_q        <= '0;
            cx_q       <= cx_init;
            ry_q       <= ry_init;
            win_ring_q <= ring_init;
            state_q    <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (i_q == i_last) begin
            i_q  <= '0;
            cx_q <= cx_init;
            if (j_q == j_last) begin
              state_q <= ST_TAIL;
            end else begin
              j_q  <= j_q + JW'(1);
              ry_q <= ry_next;
              if (ry_next > 0 && ry_next <= h_last_s) begin
                win_ring_q <= (32'(win_ring_q) == RING - 1) ? '0
                                                            : win_ring_q + RG_W'(1);
              end
            end
          end else begin
            i_q  <= i_q + IW'(1);
            cx_q <= cx_q + CX_W'(1);
          end
        end
        ST_TAIL: begin
          state_q <= ST_DIV;
        end
        ST_DIV, ST_OUT: begin
          if (state_q == ST_DIV && div_done && !out_free) begin
            state_q <= ST_OUT;
          end
          if (load_out) begin
            state_q <= ST_IDLE;
            if (((state_q == ST_DIV) ? win_last : res_last_q)) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_ring_q  <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_ring_q <= '0;
              in_done_q  <= 1'b0;
              diff_q     <= '0;
            end else begin
              diff_q <= diff_q - LAG_W'(1);
              if (32'(out_col_q) + 1 >= 32'(eff_w)) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + RowW'(1);
                out_ring_q <= (32'(out_ring_q) == RING - 1) ? '0
                                                            : out_ring_q + RG_W'(1);
              end else begin
                out_col_q <= out_col_q + CW'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_diff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (diff_q <= lag))
    else $error("pending count exceeds the window lag");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_done_q |-> (in_col_q == '0 && in_row_q == '0))
    else $error("input position not cleared at end of frame");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_box_mean_blur_clamped_edges.sv =====
// ---------------------------------------------------------------------------
// tb_box_mean_blur_clamped_edges
// Self-checking testbench for the streaming box mean filter with clamped edges.
// A directed table covers the corner cases first: the smallest and largest
// windows, drain beats mid-frame and with nothing pending, pixels after the
// frame's last pixel, and register values that are clamped. Random frames
// follow. Checked table rows give their own expected beats; all other beats
// are compared with a window-mean predictor keeping its own row memory copy.
// ---------------------------------------------------------------------------
module tb_box_mean_blur_clamped_edges;
  import bmb_pkg::*;

  localparam int unsigned RingRows  = 2 * MaxRadiusYDef + MaxRadiusXDef + 2;
  localparam int unsigned IdleWait  = 300;
  localparam int unsigned StallLim  = 4000;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned ItemGoal  = 850;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } blur_res_t;

  typedef struct packed {
    bit               is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic             cmd;
    logic [7:0]       pix;
    bit               chk;
    logic [7:0]       exp_pix;
    logic             exp_last;
  } dir_row_t;

  localparam int unsigned DirRows = 24;
  localparam dir_row_t DirTab [DirRows] = '{
    '{1'b1, RegImageWidth,  13'd1, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegImageHeight, 13'd1, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegHalfWidth,   13'd0, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegHalfHeight,  13'd0, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd255, 1'b1, 8'd255, 1'b1},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd0,   1'b1, 8'd0,   1'b1},
    '{1'b1, RegHalfWidth,   13'd7, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegHalfHeight,  13'd7, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd200, 1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdDrain, 8'd13,  1'b1, 8'd200, 1'b1},
    '{1'b1, RegImageWidth,  13'd2, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegHalfWidth,   13'd1, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b1, RegHalfHeight,  13'd0, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdDrain, 8'd255, 1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd255, 1'b1, 8'd85,  1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdDrain, 8'd0,   1'b1, 8'd170, 1'b1},
    '{1'b0, RegImageWidth,  13'd0, CmdDrain, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd10,  1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd20,  1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd99,  1'b0, 8'd0,   1'b0},
    '{1'b1, RegImageWidth,  13'd0, CmdPixel, 8'd0,   1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdPixel, 8'd77,  1'b0, 8'd0,   1'b0},
    '{1'b0, RegImageWidth,  13'd0, CmdDrain, 8'd0,   1'b1, 8'd77,  1'b1}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  box_mean_blur_clamped_edges dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor state.
  logic [7:0]  blur_ring [RingRows*MaxWidthDef];
  int unsigned reg_w, reg_h, reg_dx, reg_dy;
  int unsigned in_col, in_row, out_col, out_row;
  bit          in_done;

  blur_res_t   mean_q [$];
  int          mismatches;
  int          n_items;
  int          n_results;
  int          n_frames;
  int          burst_left;
  int          idle_cycles;
  bit          hold_req;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned width_eff();
    if (reg_w == 0) return 1;
    return (reg_w > MaxWidthDef) ? MaxWidthDef : reg_w;
  endfunction

  function automatic int unsigned height_eff();
    if (reg_h == 0) return 1;
    return (reg_h > HeightMax) ? HeightMax : reg_h;
  endfunction

  function automatic void frame_restart();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_done = 1'b0;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic blur_res_t window_mean();
    int unsigned w, h, sum, area, yy, xx;
    int          dx, dy;
    blur_res_t   r;
    w = width_eff(); h = height_eff();
    dx = (reg_dx > MaxRadiusXDef) ? MaxRadiusXDef : reg_dx;
    dy = (reg_dy > MaxRadiusYDef) ? MaxRadiusYDef : reg_dy;
    sum = 0;
    for (int j = -dy; j <= dy; j++) begin
      yy = clip(int'(out_row) + j, int'(h) - 1);
      for (int i = -dx; i <= dx; i++) begin
        xx = clip(int'(out_col) + i, int'(w) - 1);
        sum += blur_ring[(yy % RingRows) * MaxWidthDef + xx];
      end
    end
    area = (2 * dx + 1) * (2 * dy + 1);
    r.pix = 8'((sum + area / 2) / area);
    r.last = (out_row == h - 1) && (out_col == w - 1);
    if (r.last) begin
      frame_restart();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return r;
  endfunction

  function automatic bit blur_step(input logic cmd, input logic [7:0] pix,
                                   output blur_res_t r);
    int unsigned w, h, lag, n_in, n_out;
    w = width_eff(); h = height_eff();
    lag = ((reg_dy > MaxRadiusYDef) ? MaxRadiusYDef : reg_dy) * w
        + ((reg_dx > MaxRadiusXDef) ? MaxRadiusXDef : reg_dx);
    if (in_done) begin
      r = window_mean();
      return 1'b1;
    end
    if (cmd == CmdDrain) return 1'b0;
    blur_ring[(in_row % RingRows) * MaxWidthDef + in_col] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) begin
        in_row = 0;
        in_done = 1'b1;
      end
    end
    n_in = in_done ? w * h : in_row * w + in_col;
    n_out = out_row * w + out_col;
    if (n_in - n_out > lag) begin
      r = window_mean();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    s_axis_tvalid <= 1'b0;
    wait (mean_q.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegImageWidth:  reg_w  = val & 32'h7FF;
      RegImageHeight: reg_h  = val & 32'h1FFF;
      RegHalfWidth:   reg_dx = val & 32'h7;
      RegHalfHeight:  reg_dy = val & 32'h7;
      default: ;
    endcase
    frame_restart();
  endtask

  // Sends one beat and returns the predicted result, if any.
  task automatic send_beat(input logic cmd, input logic [7:0] pix,
                           output bit got, output blur_res_t r);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    got = blur_step(cmd, pix, r);
    if (cmd == CmdPixel || got) n_items++;
  endtask

  task automatic send_checked(input logic cmd, input logic [7:0] pix);
    bit        got;
    blur_res_t r;
    send_beat(cmd, pix, got, r);
    if (got) mean_q.push_back(r);
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h,
                           input int unsigned dx, input int unsigned dy,
                           input int unsigned npix, input bit hold, input bit pause);
    int unsigned first;
    first = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      case ((first + k) % 4)
        0: write_reg(RegImageWidth, w);
        1: write_reg(RegImageHeight, h);
        2: write_reg(RegHalfWidth, dx);
        default: write_reg(RegHalfHeight, dy);
      endcase
    end
    if (hold) hold_req = 1'b1;
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 9) == 0) send_checked(CmdDrain, 8'($urandom));
      send_checked(CmdPixel, 8'($urandom));
    end
    if (pause) begin
      s_axis_tvalid <= 1'b0;
      wait (mean_q.size() == 0);
      @(posedge clk_i);
    end
    while (in_done) send_checked(1'($urandom), 8'($urandom));
    send_checked(CmdDrain, 8'($urandom));
    n_frames++;
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    blur_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (mean_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: pixel %0d last %0b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = mean_q.pop_front();
        if (m_axis_tdata !== want.pix || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                     want.pix, want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    int left;
    m_axis_tready = 1'b0;
    left = 0;
    mode = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((left % 7) < 3);
      endcase
    end
  end

  // Watchdog on cycles without any accepted beat or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLim) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned w, h, dx, dy, npix;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdPixel;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegImageWidth;
    cfg_data_i    = '0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    mismatches    = 0;
    n_items       = 0;
    n_results     = 0;
    n_frames      = 0;
    burst_left    = 0;
    reg_w  = ImageWidthRst;
    reg_h  = ImageHeightRst;
    reg_dx = HalfWidthRst;
    reg_dy = HalfHeightRst;
    frame_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[k]) begin
      bit        got;
      blur_res_t r;
      if (DirTab[k].is_cfg) begin
        write_reg(DirTab[k].idx, DirTab[k].data);
      end else begin
        send_beat(DirTab[k].cmd, DirTab[k].pix, got, r);
        if (DirTab[k].chk) mean_q.push_back(blur_res_t'{DirTab[k].exp_pix,
                                                        DirTab[k].exp_last});
        else if (got) mean_q.push_back(r);
      end
    end

    // Widest image, with the width register above its limit, as a partial frame.
    run_frame(2047, 2, 7, 0, 60, 1'b0, 1'b0);
    // Tallest image, height register above its limit, partial frame.
    run_frame(1, 8191, 0, 7, 30, 1'b0, 1'b0);
    // Long receiver hold-off while pixels keep coming.
    run_frame(8, 4, 2, 1, 32, 1'b1, 1'b0);
    run_frame(5, 5, 7, 7, 25, 1'b0, 1'b1);

    while (n_items < ItemGoal) begin
      w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
      h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 6);
      dx = $urandom_range(0, 7);
      dy = $urandom_range(0, 7);
      npix = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      if ($urandom_range(0, 7) == 0) npix = $urandom_range(0, npix - 1);
      run_frame(w, h, dx, dy, npix, 1'b0, $urandom_range(0, 5) == 0);
    end

    s_axis_tvalid <= 1'b0;
    wait (mean_q.size() == 0);
    repeat (IdleWait) @(posedge clk_i);
    $display("Run covered %0d input beats over %0d frames, %0d filtered pixels checked.",
             n_items, n_frames, n_results);
    $display("Mismatches: %0d, results still outstanding: %0d.", mismatches, mean_q.size());
    if (mismatches == 0 && mean_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== box_mean_blur_clamped_edges.f =====
sv/bmb_pkg.sv
sv/bmb_div.sv
sv/box_mean_blur_clamped_edges.sv
verif/tb_box_mean_blur_clamped_edges.sv
